// ===== sv/affine_group_mod_p_unit_assert.svh =====
// assertion macros for the affine group unit
`ifndef AFFINE_GROUP_MOD_P_UNIT_ASSERT_SVH
`define AFFINE_GROUP_MOD_P_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AGM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AGM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/agm_pkg.sv =====
`default_nettype none

package agm_pkg;

    // value width of every group element field and of the modulus
    localparam int VALUE_WIDTH = 16;
    // signed width of the euclid coefficients
    localparam int COEF_WIDTH  = VALUE_WIDTH + 2;
    // step counter of the shared divider, holds up to two value widths
    localparam int CNT_WIDTH   = $clog2(2 * VALUE_WIDTH + 1);

    localparam logic [VALUE_WIDTH-1:0] MODULUS_RESET = VALUE_WIDTH'(23);

    // request codes
    localparam logic REQ_COMPOSE = 1'b0;
    localparam logic REQ_INVERT  = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [VALUE_WIDTH-1:0] a_shift;
        logic [VALUE_WIDTH-1:0] a_scale;
        logic [VALUE_WIDTH-1:0] b_shift;
        logic [VALUE_WIDTH-1:0] b_scale;
    } req_word_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] res_shift;
        logic [VALUE_WIDTH-1:0] res_scale;
        logic                   not_invertible;
    } res_word_t;

endpackage

`default_nettype wire

// ===== sv/affine_group_mod_p_unit.sv =====
`default_nettype none

// channel   | direction | handshake            | word
// ----------+-----------+----------------------+------------------------------
// request   | in        | req_valid/req_stall  | agm_pkg::req_word_t
// result    | out       | res_valid/res_stall  | agm_pkg::res_word_t
// modulus   | in        | modulus_we           | modulus_wdata, VALUE_WIDTH bits
//
// one request word is worked on at a time; req_stall is high from accept until the
// result is handed to the output register. a shared restoring divider (one bit a
// cycle) does every reduction and every euclid quotient. reset (rst_n, async,
// active low) clears the sequencer, the output valid and loads the modulus with
// 23. a result stalled on the output register does not block the next request
// word.

module affine_group_mod_p_unit
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output      logic                               req_stall,
    input  wire agm_pkg::req_word_t                 req_word,
    output      logic                               res_valid,
    input  wire logic                               res_stall,
    output      agm_pkg::res_word_t                 res_word,
    input  wire logic                               modulus_we,
    input  wire logic [agm_pkg::VALUE_WIDTH-1:0]    modulus_wdata
);

    localparam int W  = agm_pkg::VALUE_WIDTH;
    localparam int CF = agm_pkg::COEF_WIDTH;
    localparam int CW = agm_pkg::CNT_WIDTH;

    // operand being reduced
    localparam logic [1:0] OPD_A_SHIFT = 2'd0;
    localparam logic [1:0] OPD_A_SCALE = 2'd1;
    localparam logic [1:0] OPD_B_SHIFT = 2'd2;
    localparam logic [1:0] OPD_B_SCALE = 2'd3;

    // which product the multiplier forms
    localparam logic [1:0] PH_FIRST  = 2'd0;   // a_scale * b_shift
    localparam logic [1:0] PH_SECOND = 2'd1;   // a_scale * b_scale
    localparam logic [1:0] PH_INV    = 2'd2;   // inverse * a_shift

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,   // waiting for a request word
        ST_RED  = 8'b0000_0010,   // reducing operands modulo p
        ST_MUL  = 8'b0000_0100,   // product into the divider
        ST_PRED = 8'b0000_1000,   // reducing a product
        ST_EDIV = 8'b0001_0000,   // euclid division step
        ST_EUPD = 8'b0010_0000,   // euclid coefficient update
        ST_EFIN = 8'b0100_0000,   // normalize the inverse
        ST_WB   = 8'b1000_0000    // hand result to the output register
    } state_t;

    // control state
    state_t                 state_reg, state_next;
    logic [1:0]             sel_reg, sel_next;
    logic [1:0]             phase_reg, phase_next;
    logic [CW-1:0]          div_cnt_reg, div_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [W-1:0]           modulus_reg;

    // payload
    agm_pkg::req_word_t     in_reg, in_next;
    logic [W-1:0]           p_reg, p_next;
    logic [W-1:0]           as_reg, as_next;
    logic [W-1:0]           ac_reg, ac_next;
    logic [W-1:0]           bs_reg, bs_next;
    logic [W-1:0]           bc_reg, bc_next;
    logic [2*W-1:0]         div_dvd_reg, div_dvd_next;
    logic [W-1:0]           div_rem_reg, div_rem_next;
    logic [W-1:0]           div_dsr_reg, div_dsr_next;
    logic [W-1:0]           rem_prev_reg, rem_prev_next;
    logic [W-1:0]           rem_cur_reg, rem_cur_next;
    logic signed [CF-1:0]   co_prev_reg, co_prev_next;
    logic signed [CF-1:0]   co_cur_reg, co_cur_next;
    logic signed [2*CF-1:0] prod_reg, prod_next;
    logic [W-1:0]           res_shift_reg, res_shift_next;
    logic [W-1:0]           res_scale_reg, res_scale_next;
    logic                   flag_reg, flag_next;
    agm_pkg::res_word_t     out_word_reg, out_word_next;

    // divider launch
    logic                   div_start;
    logic                   div_long;
    logic [2*W-1:0]         div_value;
    logic [W-1:0]           div_divisor;

    // datapath helpers
    logic [W-1:0]           p_eff;
    logic [W:0]             div_shift;
    logic [W:0]             div_sub;
    logic                   div_ge;
    logic                   div_done;
    logic signed [CF-1:0]   mul_a;
    logic signed [CF-1:0]   mul_b;
    logic signed [2*CF-1:0] mul_out;
    logic [W:0]             add_sum;
    logic [W:0]             add_sub;
    logic [W-1:0]           add_red;
    logic signed [2*CF-1:0] co_diff;
    logic signed [CF-1:0]   co_adj;
    logic signed [CF-1:0]   co_sub;
    logic [W-1:0]           inv_val;

    // modulus zero acts as modulus one
    assign p_eff = (modulus_reg == '0) ? W'(1) : modulus_reg;

    // restoring divider step: shift in the next dividend bit, subtract if it fits
    assign div_shift = {div_rem_reg, div_dvd_reg[2*W-1]};
    assign div_sub   = div_shift - {1'b0, div_dsr_reg};
    assign div_ge    = (div_shift >= {1'b0, div_dsr_reg});
    assign div_done  = (div_cnt_reg == '0);

    // shared multiplier, signed so the euclid coefficients fit too
    always_comb
    begin
        mul_a = CF'(0);
        mul_b = CF'(0);
        case (state_reg)
            ST_EDIV:
            begin
                mul_a = {2'b00, div_dvd_reg[W-1:0]};
                mul_b = co_cur_reg;
            end
            default:
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        mul_a = {2'b00, ac_reg};
                        mul_b = {2'b00, bs_reg};
                    end
                    PH_SECOND:
                    begin
                        mul_a = {2'b00, ac_reg};
                        mul_b = {2'b00, bc_reg};
                    end
                    default:
                    begin
                        mul_a = {2'b00, res_scale_reg};
                        mul_b = {2'b00, as_reg};
                    end
                endcase
            end
        endcase
    end

    assign mul_out = mul_a * mul_b;

    // a_shift + reduced product, one conditional subtract
    assign add_sum = {1'b0, as_reg} + {1'b0, div_rem_reg};
    assign add_sub = add_sum - {1'b0, p_reg};
    assign add_red = (add_sum >= {1'b0, p_reg}) ? add_sub[W-1:0] : add_sum[W-1:0];

    // next euclid coefficient
    assign co_diff = {{CF{co_prev_reg[CF-1]}}, co_prev_reg} - prod_reg;

    // bring the final coefficient into 0..p-1
    assign co_adj  = co_prev_reg[CF-1] ? (co_prev_reg + $signed({2'b00, p_reg})) : co_prev_reg;
    assign co_sub  = co_adj - $signed({2'b00, p_reg});
    assign inv_val = (co_adj >= $signed({2'b00, p_reg})) ? co_sub[W-1:0] : co_adj[W-1:0];

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res_word  = out_word_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        in_next        = in_reg;
        p_next         = p_reg;
        as_next        = as_reg;
        ac_next        = ac_reg;
        bs_next        = bs_reg;
        bc_next        = bc_reg;
        rem_prev_next  = rem_prev_reg;
        rem_cur_next   = rem_cur_reg;
        co_prev_next   = co_prev_reg;
        co_cur_next    = co_cur_reg;
        prod_next      = prod_reg;
        res_shift_next = res_shift_reg;
        res_scale_next = res_scale_reg;
        flag_next      = flag_reg;
        out_word_next  = out_word_reg;
        div_start      = 1'b0;
        div_long       = 1'b0;
        div_value      = '0;
        div_divisor    = p_reg;

        // output word leaves
        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    in_next     = req_word;
                    p_next      = p_eff;
                    sel_next    = OPD_A_SHIFT;
                    phase_next  = PH_FIRST;
                    flag_next   = 1'b0;
                    div_start   = 1'b1;
                    div_value   = {W'(0), req_word.a_shift};
                    div_divisor = p_eff;
                    state_next  = ST_RED;
                end
            end

            ST_RED:
            begin
                if (div_done)
                begin
                    case (sel_reg)
                        OPD_A_SHIFT:
                        begin
                            as_next   = div_rem_reg;
                            sel_next  = OPD_A_SCALE;
                            div_start = 1'b1;
                            div_value = {W'(0), in_reg.a_scale};
                        end
                        OPD_A_SCALE:
                        begin
                            ac_next = div_rem_reg;
                            if (in_reg.req_type == agm_pkg::REQ_INVERT)
                            begin
                                if (div_rem_reg == '0)
                                begin
                                    // zero scale has no inverse
                                    res_shift_next = '0;
                                    res_scale_next = '0;
                                    flag_next      = 1'b1;
                                    state_next     = ST_WB;
                                end
                                else
                                begin
                                    rem_prev_next = p_reg;
                                    rem_cur_next  = div_rem_reg;
                                    co_prev_next  = CF'(0);
                                    co_cur_next   = CF'(1);
                                    div_start     = 1'b1;
                                    div_value     = {W'(0), p_reg};
                                    div_divisor   = div_rem_reg;
                                    state_next    = ST_EDIV;
                                end
                            end
                            else
                            begin
                                sel_next  = OPD_B_SHIFT;
                                div_start = 1'b1;
                                div_value = {W'(0), in_reg.b_shift};
                            end
                        end
                        OPD_B_SHIFT:
                        begin
                            bs_next   = div_rem_reg;
                            sel_next  = OPD_B_SCALE;
                            div_start = 1'b1;
                            div_value = {W'(0), in_reg.b_scale};
                        end
                        default:
                        begin
                            bc_next    = div_rem_reg;
                            state_next = ST_MUL;
                        end
                    endcase
                end
            end

            ST_MUL:
            begin
                // product goes straight into the divider register
                div_start  = 1'b1;
                div_long   = 1'b1;
                div_value  = mul_out[2*W-1:0];
                state_next = ST_PRED;
            end

            ST_PRED:
            begin
                if (div_done)
                begin
                    case (phase_reg)
                        PH_FIRST:
                        begin
                            res_shift_next = add_red;
                            phase_next     = PH_SECOND;
                            state_next     = ST_MUL;
                        end
                        PH_SECOND:
                        begin
                            res_scale_next = div_rem_reg;
                            state_next     = ST_WB;
                        end
                        default:
                        begin
                            // negate, zero stays zero
                            res_shift_next = (div_rem_reg == '0) ? W'(0) : (p_reg - div_rem_reg);
                            state_next     = ST_WB;
                        end
                    endcase
                end
            end

            ST_EDIV:
            begin
                if (div_done)
                begin
                    prod_next     = mul_out;
                    rem_prev_next = rem_cur_reg;
                    rem_cur_next  = div_rem_reg;
                    state_next    = ST_EUPD;
                end
            end

            ST_EUPD:
            begin
                co_prev_next = co_cur_reg;
                co_cur_next  = co_diff[CF-1:0];
                if (rem_cur_reg != '0)
                begin
                    div_start   = 1'b1;
                    div_value   = {W'(0), rem_prev_reg};
                    div_divisor = rem_cur_reg;
                    state_next  = ST_EDIV;
                end
                else
                begin
                    state_next = ST_EFIN;
                end
            end

            ST_EFIN:
            begin
                if (rem_prev_reg != W'(1))
                begin
                    // gcd above one, no inverse
                    res_shift_next = '0;
                    res_scale_next = '0;
                    flag_next      = 1'b1;
                    state_next     = ST_WB;
                end
                else
                begin
                    res_scale_next = inv_val;
                    phase_next     = PH_INV;
                    state_next     = ST_MUL;
                end
            end

            ST_WB:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_word_next.res_shift      = res_shift_reg;
                    out_word_next.res_scale      = res_scale_reg;
                    out_word_next.not_invertible = flag_reg;
                    out_valid_next               = 1'b1;
                    state_next                   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // shared divider: load on start, else step while the count runs
    always_comb
    begin
        div_cnt_next = div_cnt_reg;
        div_dvd_next = div_dvd_reg;
        div_rem_next = div_rem_reg;
        div_dsr_next = div_dsr_reg;
        if (div_start)
        begin
            div_rem_next = '0;
            div_dsr_next = div_divisor;
            if (div_long)
            begin
                div_dvd_next = div_value;
                div_cnt_next = CW'(2 * W);
            end
            else
            begin
                // short run: quotient lands in the low half
                div_dvd_next = {div_value[W-1:0], W'(0)};
                div_cnt_next = CW'(W);
            end
        end
        else if (!div_done)
        begin
            div_rem_next = div_ge ? div_sub[W-1:0] : div_shift[W-1:0];
            div_dvd_next = {div_dvd_reg[2*W-2:0], div_ge};
            div_cnt_next = div_cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= OPD_A_SHIFT;
            phase_reg     <= PH_FIRST;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            modulus_reg   <= agm_pkg::MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            phase_reg     <= phase_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            if (modulus_we)
            begin
                modulus_reg <= modulus_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg        <= in_next;
        p_reg         <= p_next;
        as_reg        <= as_next;
        ac_reg        <= ac_next;
        bs_reg        <= bs_next;
        bc_reg        <= bc_next;
        div_dvd_reg   <= div_dvd_next;
        div_rem_reg   <= div_rem_next;
        div_dsr_reg   <= div_dsr_next;
        rem_prev_reg  <= rem_prev_next;
        rem_cur_reg   <= rem_cur_next;
        co_prev_reg   <= co_prev_next;
        co_cur_reg    <= co_cur_next;
        prod_reg      <= prod_next;
        res_shift_reg <= res_shift_next;
        res_scale_reg <= res_scale_next;
        flag_reg      <= flag_next;
        out_word_reg  <= out_word_next;
    end

    // checks
`include "affine_group_mod_p_unit_assert.svh"

    `AGM_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, state_reg != ST_IDLE, "request accepted but sequencer idle")
    `AGM_ASSERT_NEXT(a_result_loaded, (state_reg == ST_WB) && (!res_valid || !res_stall), res_valid && (state_reg == ST_IDLE), "result not loaded into output register")
    `AGM_ASSERT_SAME(a_euclid_ends_on_zero, state_reg == ST_EFIN, rem_cur_reg == '0, "euclid finished with nonzero remainder")
    `AGM_ASSERT_SAME(a_flag_zero_result, res_valid && res_word.not_invertible, (res_word.res_shift == '0) && (res_word.res_scale == '0), "not invertible with nonzero result")

endmodule

`default_nettype wire
